// ----- sv/msd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and helper functions for the dual countdown
// seven-segment driver.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int DIGIT_W     = 4;
  localparam int IDX_W       = 2;
  localparam int VAL_W       = 7;
  localparam int SEG_W       = 7;
  localparam int PERIOD_W    = 8;
  localparam int CMD_W       = 3;

  localparam logic [VAL_W-1:0]    MAX_VALUE          = 7'd99;
  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET  = 8'd25;
  localparam logic [PERIOD_W-1:0] COUNT_PERIOD_RESET = 8'd100;
  localparam logic [SEG_W-1:0]    SEG_OFF            = 7'h7f;
  localparam logic [DIGIT_COUNT-1:0] EN_OFF          = 4'hf;

  // configuration register indexes
  localparam logic CFG_SCAN_PERIOD  = 1'b0;
  localparam logic CFG_COUNT_PERIOD = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_LOAD1 = 3'd1,
    CMD_LOAD2 = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_SHOW1 = 3'd4,
    CMD_SHOW2 = 3'd5
  } cmd_t;

  typedef struct packed {
    logic step;  // a tick transaction is being taken
    logic arm;   // timer may fire and reload on this tick
  } timer_ctrl_t;

  // active-low segment pattern, bit0 = a .. bit6 = g
  function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

  // tens digit of a value up to 99: (v * 103) >> 10 is exact below 179
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [VAL_W-1:0] v);
    logic [16:0] p;
    p = {10'd0, v} * 17'd103;
    return p[13:10];
  endfunction

  function automatic logic [DIGIT_W-1:0] units_of(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] t10;
    logic [VAL_W-1:0] r;
    t10 = {3'd0, tens_of(v)} * 7'd10;
    r   = v - t10;
    return r[DIGIT_W-1:0];
  endfunction

endpackage

// ----- sv/msd_reload_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_reload_timer
// Reload down-counter that starts expired. Advances on each tick; fires when
// expired and armed, then reloads with the period.
// ----------------------------------------------------------------------------
module msd_reload_timer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msd_pkg::timer_ctrl_t         ctrl,
  input  logic [msd_pkg::PERIOD_W-1:0] period,
  output logic                         fire
);

  logic [msd_pkg::PERIOD_W-1:0] timer_r, timer_nxt;
  logic                         expired_r, expired_nxt;
  logic [msd_pkg::PERIOD_W-1:0] run_timer;
  logic                         run_expired;

  always_comb begin
    run_timer   = timer_r;
    run_expired = expired_r;
    if (!expired_r) begin
      if (timer_r <= 8'd1) begin
        run_timer   = '0;
        run_expired = 1'b1;
      end else begin
        run_timer = timer_r - 8'd1;
      end
    end
  end

  assign fire = ctrl.step && run_expired && ctrl.arm;

  always_comb begin
    timer_nxt   = timer_r;
    expired_nxt = expired_r;
    if (ctrl.step) begin
      timer_nxt   = run_timer;
      expired_nxt = run_expired;
      if (fire) begin
        timer_nxt   = period;
        expired_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r   <= '0;
      expired_r <= 1'b1;
    end else begin
      timer_r   <= timer_nxt;
      expired_r <= expired_nxt;
    end
  end

endmodule

// ----- sv/mux_seven_segment_dual_countdown_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mux_seven_segment_dual_countdown_core
// Four-digit multiplexed seven-segment driver with two two-digit countdowns.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / fields (lsb first)
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | command[2:0], load_value[9:3], zero pad to 16
//  out_    | master    | digit_enables[3:0], segments[10:4], count_one[17:11],
//          |           | count_two[24:18], zero pad to 32
//  cfg_    | write     | idx 0 scan_period, idx 1 count_period, 8-bit data
//
// one transaction per cycle; each command is applied in the cycle it is taken
// and its result appears in the output register on the next cycle.
// in_tready drops only when the output register is full and not being taken.
// synchronous active-low reset: display blank, counts zero, both timers
// expired so the first armed tick fires each; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mux_seven_segment_dual_countdown_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // command[2:0], load_value[9:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digit_enables[3:0], segments[10:4],
                                  // count_one[17:11], count_two[24:18]
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  localparam int DW = msd_pkg::DIGIT_W;
  localparam int VW = msd_pkg::VAL_W;

  // configuration
  logic [msd_pkg::PERIOD_W-1:0] scan_period_r, count_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r  <= msd_pkg::SCAN_PERIOD_RESET;
      count_period_r <= msd_pkg::COUNT_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        msd_pkg::CFG_SCAN_PERIOD:  scan_period_r  <= cfg_wdata;
        msd_pkg::CFG_COUNT_PERIOD: count_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input decode
  logic           in_fire;
  logic [2:0]     cmd;
  logic [VW-1:0]  raw_val, val;

  assign in_fire = in_tvalid && in_tready;
  assign cmd     = in_tdata[2:0];
  assign raw_val = in_tdata[9:3];
  assign val     = (raw_val > msd_pkg::MAX_VALUE) ? msd_pkg::MAX_VALUE : raw_val;

  // state
  logic [DW-1:0]                  digit_r [msd_pkg::DIGIT_COUNT];
  logic [DW-1:0]                  digit_nxt [msd_pkg::DIGIT_COUNT];
  logic [msd_pkg::IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic [VW-1:0]                  count1_r, count1_nxt, count2_r, count2_nxt;
  logic [msd_pkg::DIGIT_COUNT-1:0] en_r, en_nxt;
  logic [msd_pkg::SEG_W-1:0]      seg_r, seg_nxt;

  logic                 is_tick, counts_nz, scan_fire, count_fire;
  msd_pkg::timer_ctrl_t scan_ctrl, count_ctrl;

  assign is_tick   = in_fire && (cmd == msd_pkg::CMD_TICK);
  assign counts_nz = (count1_r != '0) || (count2_r != '0);

  assign scan_ctrl.step  = is_tick;
  assign scan_ctrl.arm   = 1'b1;
  assign count_ctrl.step = is_tick;
  assign count_ctrl.arm  = counts_nz;

  msd_reload_timer u_scan_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (scan_ctrl),
    .period (scan_period_r),
    .fire   (scan_fire)
  );

  msd_reload_timer u_count_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (count_ctrl),
    .period (count_period_r),
    .fire   (count_fire)
  );

  always_comb begin
    digit_nxt    = digit_r;
    scan_idx_nxt = scan_idx_r;
    count1_nxt   = count1_r;
    count2_nxt   = count2_r;
    en_nxt       = en_r;
    seg_nxt      = seg_r;
    if (in_fire) begin
      case (cmd)
        msd_pkg::CMD_TICK: begin
          // scan reads the digits as they stood before this tick's countdown
          if (scan_fire) begin
            en_nxt       = ~(4'b0001 << scan_idx_r);
            seg_nxt      = msd_pkg::seg_decode(digit_r[scan_idx_r]);
            scan_idx_nxt = scan_idx_r + 2'd1;
          end
          if (count_fire) begin
            if (count1_r != '0) begin
              digit_nxt[0] = msd_pkg::tens_of(count1_r);
              digit_nxt[1] = msd_pkg::units_of(count1_r);
              count1_nxt   = count1_r - 7'd1;
            end
            if (count2_r != '0) begin
              digit_nxt[2] = msd_pkg::tens_of(count2_r);
              digit_nxt[3] = msd_pkg::units_of(count2_r);
              count2_nxt   = count2_r - 7'd1;
            end
          end
        end
        msd_pkg::CMD_LOAD1: count1_nxt = val;
        msd_pkg::CMD_LOAD2: count2_nxt = val;
        msd_pkg::CMD_STOP: begin
          count1_nxt = '0;
          count2_nxt = '0;
        end
        msd_pkg::CMD_SHOW1: begin
          digit_nxt[0] = msd_pkg::tens_of(val);
          digit_nxt[1] = msd_pkg::units_of(val);
        end
        msd_pkg::CMD_SHOW2: begin
          digit_nxt[2] = msd_pkg::tens_of(val);
          digit_nxt[3] = msd_pkg::units_of(val);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msd_pkg::DIGIT_COUNT; i++) begin
        digit_r[i] <= '0;
      end
      scan_idx_r <= '0;
      count1_r   <= '0;
      count2_r   <= '0;
      en_r       <= msd_pkg::EN_OFF;
      seg_r      <= msd_pkg::SEG_OFF;
    end else begin
      digit_r    <= digit_nxt;
      scan_idx_r <= scan_idx_nxt;
      count1_r   <= count1_nxt;
      count2_r   <= count2_nxt;
      en_r       <= en_nxt;
      seg_r      <= seg_nxt;
    end
  end

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, count2_nxt, count1_nxt, seg_nxt, en_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted transaction did not produce a result");

  a_one_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(~out_tdata[3:0]))
    else $error("more than one digit enabled");

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count1_r <= msd_pkg::MAX_VALUE) && (count2_r <= msd_pkg::MAX_VALUE))
    else $error("countdown above 99");

  a_scan_advances: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire |=> scan_idx_r == $past(scan_idx_r) + 2'd1)
    else $error("scan index did not advance");
`endif

endmodule

// ----- tb/mux_seven_segment_dual_countdown_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mux_seven_segment_dual_countdown_core_tb
// Self-checking bench for the four-digit display driver with two countdowns.
// A queue-fed driver sends tick, load, stop and show commands with random
// gaps. A monitor takes results under random back-pressure and compares them
// with a built-in display model. Both periods are rewritten between phases,
// zero and full scale included.
// ----------------------------------------------------------------------------
module mux_seven_segment_dual_countdown_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 100;
  localparam int PHASE_COUNT    = 8;

  // period pairs for the fixed phases
  localparam int SCAN_SET  [6] = '{0, 1, 255, 2, 255, 1};
  localparam int COUNT_SET [6] = '{0, 1, 255, 3, 1, 255};

  // codes outside the enum that the block must ignore
  localparam logic [msd_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [msd_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // active-low font, bit0 = a .. bit6 = g, blank above nine
  localparam logic [msd_pkg::SEG_W-1:0] FONT [16] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78,
    7'h00, 7'h10, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f
  };

  typedef struct packed {
    logic [msd_pkg::DIGIT_COUNT-1:0] enables;
    logic [msd_pkg::SEG_W-1:0]       segments;
    logic [msd_pkg::VAL_W-1:0]       count_one;
    logic [msd_pkg::VAL_W-1:0]       count_two;
  } display_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic        cfg_idx    = msd_pkg::CFG_SCAN_PERIOD;
  logic [7:0]  cfg_wdata  = '0;

  mux_seven_segment_dual_countdown_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // display model state
  logic [msd_pkg::PERIOD_W-1:0]    scan_period_q  = msd_pkg::SCAN_PERIOD_RESET;
  logic [msd_pkg::PERIOD_W-1:0]    count_period_q = msd_pkg::COUNT_PERIOD_RESET;
  logic [msd_pkg::DIGIT_W-1:0]     shown [msd_pkg::DIGIT_COUNT] = '{default: '0};
  logic [msd_pkg::IDX_W-1:0]       scan_ptr       = '0;
  logic [msd_pkg::PERIOD_W-1:0]    scan_left      = '0;
  logic                            scan_fired     = 1'b1;
  logic [msd_pkg::PERIOD_W-1:0]    count_left     = '0;
  logic                            count_fired    = 1'b1;
  logic [msd_pkg::VAL_W-1:0]       countdown_one  = '0;
  logic [msd_pkg::VAL_W-1:0]       countdown_two  = '0;
  logic [msd_pkg::DIGIT_COUNT-1:0] enables_q      = msd_pkg::EN_OFF;
  logic [msd_pkg::SEG_W-1:0]       segments_q     = msd_pkg::SEG_OFF;

  logic [15:0] command_queue [$];
  display_t    display_expected [$];
  bit          presenting   = 0;
  int          in_gap       = 0;
  int          in_calm      = 0;
  int          out_hold     = 0;
  int          out_calm     = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] pack_command(logic [msd_pkg::CMD_W-1:0] cmd,
                                               logic [msd_pkg::VAL_W-1:0] v);
    return {6'd0, v, cmd};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void write_pair(int first, logic [msd_pkg::VAL_W-1:0] v);
    shown[first]     = msd_pkg::DIGIT_W'(v / 10);
    shown[first + 1] = msd_pkg::DIGIT_W'(v % 10);
  endfunction

  function automatic display_t apply_command(logic [15:0] item);
    logic [msd_pkg::CMD_W-1:0] cmd;
    logic [msd_pkg::VAL_W-1:0] v;
    display_t                  res;
    cmd = item[2:0];
    v   = (item[9:3] > msd_pkg::MAX_VALUE) ? msd_pkg::MAX_VALUE : item[9:3];
    case (cmd)
      msd_pkg::CMD_TICK: begin
        if (!scan_fired) begin
          if (scan_left <= 1) begin
            scan_left  = '0;
            scan_fired = 1'b1;
          end else begin
            scan_left = scan_left - 1'b1;
          end
        end
        if (!count_fired) begin
          if (count_left <= 1) begin
            count_left  = '0;
            count_fired = 1'b1;
          end else begin
            count_left = count_left - 1'b1;
          end
        end
        if (scan_fired) begin
          enables_q  = ~(msd_pkg::DIGIT_COUNT'(1) << scan_ptr);
          segments_q = FONT[shown[scan_ptr]];
          scan_ptr   = scan_ptr + 1'b1;
          scan_left  = scan_period_q;
          scan_fired = 1'b0;
        end
        // with both counts at zero the count timer stays expired
        if (count_fired && (countdown_one != 0 || countdown_two != 0)) begin
          if (countdown_one != 0) begin
            write_pair(0, countdown_one);
            countdown_one = countdown_one - 1'b1;
          end
          if (countdown_two != 0) begin
            write_pair(2, countdown_two);
            countdown_two = countdown_two - 1'b1;
          end
          count_left  = count_period_q;
          count_fired = 1'b0;
        end
      end
      msd_pkg::CMD_LOAD1: countdown_one = v;
      msd_pkg::CMD_LOAD2: countdown_two = v;
      msd_pkg::CMD_STOP: begin
        countdown_one = '0;
        countdown_two = '0;
      end
      msd_pkg::CMD_SHOW1: write_pair(0, v);
      msd_pkg::CMD_SHOW2: write_pair(2, v);
      default: ;
    endcase
    res.enables   = enables_q;
    res.segments  = segments_q;
    res.count_one = countdown_one;
    res.count_two = countdown_two;
    return res;
  endfunction

  function automatic logic [15:0] random_command();
    int                        r;
    logic [msd_pkg::CMD_W-1:0] cmd;
    logic [msd_pkg::VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 55)      cmd = msd_pkg::CMD_TICK;
    else if (r < 63) cmd = msd_pkg::CMD_LOAD1;
    else if (r < 71) cmd = msd_pkg::CMD_LOAD2;
    else if (r < 75) cmd = msd_pkg::CMD_STOP;
    else if (r < 83) cmd = msd_pkg::CMD_SHOW1;
    else if (r < 91) cmd = msd_pkg::CMD_SHOW2;
    else if (r < 95) cmd = CMD_SPARE6;
    else             cmd = CMD_SPARE7;
    // small loads let the countdowns reach zero often
    r = $urandom_range(0, 99);
    if (r < 40)      v = msd_pkg::VAL_W'($urandom_range(0, 9));
    else if (r < 85) v = msd_pkg::VAL_W'($urandom_range(0, 99));
    else             v = msd_pkg::VAL_W'($urandom_range(100, 127));
    return pack_command(cmd, v);
  endfunction

  // command driver
  always @(negedge clk) begin
    if (!presenting) begin
      if (in_gap > 0) begin
        in_gap    = in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (command_queue.size() > 0) begin
        in_tdata   <= command_queue[0];
        in_tvalid  <= 1'b1;
        presenting = 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // accepted commands feed the model
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      display_expected.push_back(apply_command(in_tdata));
      void'(command_queue.pop_front());
      presenting = 0;
      if (in_calm > 0) begin
        in_calm = in_calm - 1;
        in_gap  = 0;
      end else begin
        in_gap = pick_gap();
        if ($urandom_range(0, 19) == 0) in_calm = $urandom_range(20, 80);
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold   = out_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_calm > 0) begin
        out_calm = out_calm - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_hold = pick_gap();
        if ($urandom_range(0, 9) == 0) out_calm = $urandom_range(20, 80);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.enables   = out_tdata[3:0];
      got.segments  = out_tdata[10:4];
      got.count_one = out_tdata[17:11];
      got.count_two = out_tdata[24:18];
      if (display_expected.size() == 0) begin
        $error("result transaction with nothing pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = display_expected.pop_front();
        if (got.enables !== want.enables) begin
          $error("digit_enables: expected %h, got %h", want.enables, got.enables);
          mismatches++;
        end
        if (got.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, got.segments);
          mismatches++;
        end
        if (got.count_one !== want.count_one) begin
          $error("count_one: expected %0d, got %0d", want.count_one, got.count_one);
          mismatches++;
        end
        if (got.count_two !== want.count_two) begin
          $error("count_two: expected %0d, got %0d", want.count_two, got.count_two);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("mux_seven_segment_dual_countdown_core test failed");
        $finish;
      end
    end
  end

  // hold the sender until every result has been taken
  task automatic drain();
    while (command_queue.size() != 0 || presenting || display_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_periods(logic [7:0] scan, logic [7:0] count);
    cfg_we    <= 1'b1;
    cfg_idx   <= msd_pkg::CFG_SCAN_PERIOD;
    cfg_wdata <= scan;
    @(posedge clk);
    scan_period_q = scan;
    @(negedge clk);
    cfg_idx   <= msd_pkg::CFG_COUNT_PERIOD;
    cfg_wdata <= count;
    @(posedge clk);
    count_period_q = count;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset periods: first tick fires the scan timer, loads and shows saturate
    command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd0));
    command_queue.push_back(pack_command(msd_pkg::CMD_SHOW1, 7'd127));
    command_queue.push_back(pack_command(msd_pkg::CMD_SHOW2, 7'd0));
    command_queue.push_back(pack_command(msd_pkg::CMD_LOAD1, 7'd127));
    command_queue.push_back(pack_command(msd_pkg::CMD_LOAD2, 7'd0));
    command_queue.push_back(pack_command(CMD_SPARE6, 7'd127));
    command_queue.push_back(pack_command(CMD_SPARE7, 7'd0));
    // count timer stayed expired while both counts were zero
    command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd127));
    command_queue.push_back(pack_command(msd_pkg::CMD_STOP, 7'd127));
    command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd0));
    command_queue.push_back(pack_command(msd_pkg::CMD_LOAD2, 7'd1));
    command_queue.push_back(pack_command(msd_pkg::CMD_LOAD1, 7'd0));
    drain();

    // zero periods act as one
    set_periods(8'd0, 8'd0);
    command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd0));
    command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd0));
    command_queue.push_back(pack_command(msd_pkg::CMD_LOAD1, 7'd2));
    repeat (4) command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd0));
    command_queue.push_back(pack_command(msd_pkg::CMD_SHOW1, 7'd45));
    command_queue.push_back(pack_command(msd_pkg::CMD_SHOW2, 7'd67));
    command_queue.push_back(pack_command(msd_pkg::CMD_LOAD2, 7'd99));
    repeat (4) command_queue.push_back(pack_command(msd_pkg::CMD_TICK, 7'd0));
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 6)
        set_periods(8'(SCAN_SET[p]), 8'(COUNT_SET[p]));
      else
        set_periods(8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)));
      for (int i = 0; i < PHASE_ITEMS; i++)
        command_queue.push_back(random_command());
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("mux_seven_segment_dual_countdown_core test passed");
    else
      $display("mux_seven_segment_dual_countdown_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/msd_pkg.sv
sv/msd_reload_timer.sv
sv/mux_seven_segment_dual_countdown_core.sv
tb/mux_seven_segment_dual_countdown_core_tb.sv
